/* design/smse_pkg.sv */
`timescale 1ns / 1ps

package smse_pkg;

  localparam int ACC_W  = 42;
  localparam int STEP_W = 4;

  localparam logic [23:0]      Q24_MAX = 24'hFFFFFF;
  localparam logic [ACC_W-1:0] RND_Q12 = ACC_W'(32'h800);
  localparam logic [ACC_W-1:0] RND_Q16 = ACC_W'(32'h8000);
  localparam logic [16:0]      ONE_Q16 = 17'h10000;

  localparam logic [15:0] SMOOTHING_RST     = 16'd58982;
  localparam logic [15:0] FILAMENT_AREA_RST = 16'd8317;
  localparam logic [14:0] RETRACT_LIMIT_RST = 15'd6400;

  typedef enum logic [1:0] {
    REG_SMOOTHING     = 2'd0,
    REG_FILAMENT_AREA = 2'd1,
    REG_RETRACT_LIMIT = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic               block_present;
    logic               moves_xy;
    logic               moves_z;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
    logic signed [15:0] speed_e;
  } in_item_t;

  typedef struct packed {
    logic [23:0] xy_speed_out;
    logic [23:0] flow_out;
    logic        retract_seen;
  } out_item_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    A_NONE, A_AX, A_AY, A_AREA, A_XY_AVG, A_FLOW_AVG, A_XY_SMP, A_FLOW_SMP
  } mul_a_t;

  typedef enum logic [2:0] {
    B_NONE, B_AX, B_AY, B_SE, B_SMOOTH, B_WEIGHT
  } mul_b_t;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_LOAD_R12, ACC_LOAD_R16, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_REM, WR_FLOW_SMP, WR_XY_AVG, WR_FLOW_AVG
  } wr_t;

  // hold: stay on the current step while the condition is true
  typedef enum logic [1:0] {
    H_NONE, H_NO_INPUT, H_ROOT_BUSY, H_OUT_BUSY
  } hold_t;

  typedef struct packed {
    logic    ld_in;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    acc_op_t acc_op;
    wr_t     wr;
    logic    root_step;
    logic    out_load;
    hold_t   hold;
    logic    jump;
    step_t   target;
  } ctl_t;

  localparam ctl_t CTL_IDLE = '{
    ld_in: 1'b0, mul_a: A_NONE, mul_b: B_NONE, acc_op: ACC_HOLD, wr: WR_NONE,
    root_step: 1'b0, out_load: 1'b0, hold: H_NONE, jump: 1'b1, target: '0
  };

  function automatic ctl_t ucode(input step_t step);
    ctl_t c;
    c = CTL_IDLE;
    c.jump = 1'b0;
    unique case (step)
      4'd0: begin
        c.ld_in = 1'b1;
        c.hold  = H_NO_INPUT;
      end
      4'd1: begin
        c.mul_a  = A_AX;
        c.mul_b  = B_AX;
        c.acc_op = ACC_LOAD;
      end
      4'd2: begin
        c.mul_a  = A_AY;
        c.mul_b  = B_AY;
        c.acc_op = ACC_ADD;
        c.wr     = WR_REM;
      end
      4'd3: begin
        c.root_step = 1'b1;
        c.hold      = H_ROOT_BUSY;
      end
      4'd4: begin
        c.mul_a  = A_AREA;
        c.mul_b  = B_SE;
        c.acc_op = ACC_LOAD_R12;
        c.wr     = WR_FLOW_SMP;
      end
      4'd5: begin
        c.mul_a  = A_XY_AVG;
        c.mul_b  = B_SMOOTH;
        c.acc_op = ACC_LOAD_R16;
      end
      4'd6: begin
        c.mul_a  = A_XY_SMP;
        c.mul_b  = B_WEIGHT;
        c.acc_op = ACC_ADD;
        c.wr     = WR_XY_AVG;
      end
      4'd7: begin
        c.mul_a  = A_FLOW_AVG;
        c.mul_b  = B_SMOOTH;
        c.acc_op = ACC_LOAD_R16;
      end
      4'd8: begin
        c.mul_a  = A_FLOW_SMP;
        c.mul_b  = B_WEIGHT;
        c.acc_op = ACC_ADD;
        c.wr     = WR_FLOW_AVG;
      end
      4'd9: begin
        c.out_load = 1'b1;
        c.hold     = H_OUT_BUSY;
        c.jump     = 1'b1;
        c.target   = 4'd0;
      end
      default: c = CTL_IDLE;
    endcase
    return c;
  endfunction

endpackage

/* design/smoothed_motion_speed_estimator.sv */
`timescale 1ns / 1ps

// Smoothed motion speed estimator.
// in channel (in_valid/in_ready/in_item): one request per update tick with the
// current segment flags and X, Y, extruder speeds.
// out channel (out_valid/out_ready/out_item): one result per request, carrying
// the filtered XY speed and extrusion rate (Q16.8) and the retract flag.
// cfg port: cfg_write/cfg_index/cfg_data writes smoothing (0), filament area (1)
// and retract limit (2); other indexes are dropped.
// A microcode sequencer steps one shared 24x17 multiplier through the squares,
// the flow product and both filter updates, and the square root runs one
// result bit per cycle.
// One request is in flight at a time; the next is taken as soon as the result
// sits in the output register, so a stalled receiver delays only the
// hand-off of the following result.
// Reset (rst, synchronous) clears both filtered values, loads the register
// defaults and leaves the sequencer waiting for a request.
module smoothed_motion_speed_estimator #(
  parameter int ROOT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  smse_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output smse_pkg::out_item_t out_item,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int CW    = (2 * ROOT_BITS + 2 > 32) ? 2 * ROOT_BITS + 2 : 32;
  localparam int CNT_W = $clog2(ROOT_BITS);
  localparam int SW    = (ROOT_BITS + 8 > 24) ? ROOT_BITS + 8 : 24;

  logic [15:0] smoothing;
  logic [15:0] filament_area;
  logic [14:0] retract_limit;

  smse_pkg::step_t    pc, pc_next;
  smse_pkg::ctl_t     ctl;
  smse_pkg::in_item_t item;

  logic [23:0] xy_avg, flow_avg, flow_smp;
  logic [ROOT_BITS-1:0] root;
  logic [31:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [smse_pkg::ACC_W-1:0] acc, acc_sum;

  logic [15:0] ax, ay;
  logic [16:0] weight;
  logic [23:0] mul_a;
  logic [16:0] mul_b;
  logic [40:0] product;
  logic        use_xy, flow_en, held;
  logic [23:0] xy_smp;
  logic [SW-1:0] root_q;
  logic [CW-1:0] trial;
  logic [CNT_W:0]   sh_root;
  logic [CNT_W+1:0] sh_bit;

  function automatic logic [23:0] sat_q24(input logic [smse_pkg::ACC_W-1:0] v);
    return (v > smse_pkg::ACC_W'(smse_pkg::Q24_MAX)) ? smse_pkg::Q24_MAX : v[23:0];
  endfunction

  assign ctl      = smse_pkg::ucode(pc);
  assign in_ready = ctl.ld_in;

  assign ax     = item.speed_x[15] ? 16'(-item.speed_x) : item.speed_x;
  assign ay     = item.speed_y[15] ? 16'(-item.speed_y) : item.speed_y;
  assign weight = smse_pkg::ONE_Q16 - 17'(smoothing);
  assign use_xy = item.block_present & item.moves_xy;
  assign flow_en = !item.block_present
                 || (item.moves_xy && !item.speed_e[15] && item.speed_e[14:0] < retract_limit);

  assign root_q = SW'(root) << 8;
  assign xy_smp = !use_xy ? '0
                : (root_q > SW'(smse_pkg::Q24_MAX)) ? smse_pkg::Q24_MAX : root_q[23:0];

  // trial = ((root << 1) + bit) << i, with i = cnt
  assign sh_root = {1'b0, cnt} + 1'b1;
  assign sh_bit  = {1'b0, cnt, 1'b0};
  assign trial   = (CW'(root) << sh_root) + (CW'(1) << sh_bit);

  always_comb begin
    unique case (ctl.mul_a)
      smse_pkg::A_AX:       mul_a = 24'(ax);
      smse_pkg::A_AY:       mul_a = 24'(ay);
      smse_pkg::A_AREA:     mul_a = 24'(filament_area);
      smse_pkg::A_XY_AVG:   mul_a = xy_avg;
      smse_pkg::A_FLOW_AVG: mul_a = flow_avg;
      smse_pkg::A_XY_SMP:   mul_a = xy_smp;
      smse_pkg::A_FLOW_SMP: mul_a = item.block_present ? flow_smp : '0;
      default:              mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.mul_b)
      smse_pkg::B_AX:     mul_b = 17'(ax);
      smse_pkg::B_AY:     mul_b = 17'(ay);
      smse_pkg::B_SE:     mul_b = 17'(item.speed_e[14:0]);
      smse_pkg::B_SMOOTH: mul_b = 17'(smoothing);
      smse_pkg::B_WEIGHT: mul_b = weight;
      default:            mul_b = '0;
    endcase
  end

  assign product = 41'(mul_a) * 41'(mul_b);

  always_comb begin
    unique case (ctl.acc_op)
      smse_pkg::ACC_LOAD:     acc_sum = smse_pkg::ACC_W'(product);
      smse_pkg::ACC_LOAD_R12: acc_sum = smse_pkg::ACC_W'(product) + smse_pkg::RND_Q12;
      smse_pkg::ACC_LOAD_R16: acc_sum = smse_pkg::ACC_W'(product) + smse_pkg::RND_Q16;
      smse_pkg::ACC_ADD:      acc_sum = acc + smse_pkg::ACC_W'(product);
      default:                acc_sum = acc;
    endcase
  end

  always_comb begin
    unique case (ctl.hold)
      smse_pkg::H_NO_INPUT:  held = !in_valid;
      smse_pkg::H_ROOT_BUSY: held = (cnt != '0);
      smse_pkg::H_OUT_BUSY:  held = out_valid && !out_ready;
      default:               held = 1'b0;
    endcase
  end

  always_comb begin
    if (held) begin
      pc_next = pc;
    end else if (ctl.jump) begin
      pc_next = ctl.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  // control and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc            <= '0;
      out_valid     <= 1'b0;
      xy_avg        <= '0;
      flow_avg      <= '0;
      smoothing     <= smse_pkg::SMOOTHING_RST;
      filament_area <= smse_pkg::FILAMENT_AREA_RST;
      retract_limit <= smse_pkg::RETRACT_LIMIT_RST;
    end else begin
      pc <= pc_next;
      if (ctl.out_load && !held) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.wr == smse_pkg::WR_XY_AVG) begin
        xy_avg <= sat_q24(acc_sum >> 16);
      end
      if (ctl.wr == smse_pkg::WR_FLOW_AVG && flow_en) begin
        flow_avg <= sat_q24(acc_sum >> 16);
      end
      if (cfg_write) begin
        case (cfg_index)
          smse_pkg::REG_SMOOTHING:     smoothing     <= cfg_data;
          smse_pkg::REG_FILAMENT_AREA: filament_area <= cfg_data;
          smse_pkg::REG_RETRACT_LIMIT: retract_limit <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    acc <= acc_sum;
    if (ctl.ld_in && in_valid) begin
      item <= in_item;
    end
    if (ctl.wr == smse_pkg::WR_REM) begin
      rem  <= acc_sum[31:0];
      root <= '0;
      cnt  <= CNT_W'(ROOT_BITS - 1);
    end else if (ctl.root_step) begin
      if (CW'(rem) >= trial) begin
        root <= root | (ROOT_BITS'(1) << cnt);
        rem  <= rem - trial[31:0];
      end
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
    if (ctl.wr == smse_pkg::WR_FLOW_SMP) begin
      flow_smp <= sat_q24(acc_sum >> 12);
    end
    if (ctl.out_load && !held) begin
      out_item.xy_speed_out <= xy_avg;
      out_item.flow_out     <= flow_avg;
      out_item.retract_seen <= item.block_present & !item.moves_xy & !item.moves_z;
    end
  end

endmodule

/* tb/smoothed_motion_speed_estimator_test.sv */
`timescale 1ns / 1ps

module smoothed_motion_speed_estimator_test;

  localparam int ROOT_BITS   = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 40;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  smse_pkg::in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  smse_pkg::out_item_t out_item;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  smoothed_motion_speed_estimator #(
    .ROOT_BITS(ROOT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers and filter state
  logic [15:0] cfg_smoothing;
  logic [15:0] cfg_area;
  logic [14:0] cfg_retract_limit;
  logic [23:0] avg_xy;
  logic [23:0] avg_flow;

  smse_pkg::out_item_t expected_speeds[$];

  bit send_idle;
  bit recv_idle;
  int long_hold_req;
  int quiet_cycles;
  int fail_count;
  int requests_sent;
  int results_checked;
  int reg_writes;
  int retract_count;
  int flow_updates;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap(input bit idle_on);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // bit-serial root, one result bit per pass
  function automatic logic [63:0] xy_root(input logic [63:0] sum_sq);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] b;
    logic [63:0] trial;
    rem  = sum_sq;
    root = '0;
    for (int i = ROOT_BITS - 1; i >= 0; i--) begin
      b     = 64'd1 << i;
      trial = ((root << 1) + b) << i;
      if (rem >= trial) begin
        root = root + b;
        rem  = rem - trial;
      end
    end
    return root;
  endfunction

  function automatic logic [23:0] smooth(input logic [23:0] old, input logic [63:0] sample);
    logic [63:0] w;
    logic [63:0] acc;
    w = {48'd0, cfg_smoothing};
    if (sample > 64'hFFFFFF) sample = 64'hFFFFFF;
    acc = (64'(old) * w + sample * (64'd65536 - w) + 64'h8000) >> 16;
    if (acc > 64'hFFFFFF) acc = 64'hFFFFFF;
    return acc[23:0];
  endfunction

  task automatic predict_update(input smse_pkg::in_item_t r);
    logic [31:0] ax;
    logic [31:0] ay;
    logic [63:0] sum_sq;
    logic [63:0] flow_smp;
    smse_pkg::out_item_t want;
    want = '0;
    if (r.block_present) begin
      if (r.moves_xy) begin
        ax = r.speed_x[15] ? 32'(-int'(r.speed_x)) : 32'(int'(r.speed_x));
        ay = r.speed_y[15] ? 32'(-int'(r.speed_y)) : 32'(int'(r.speed_y));
        sum_sq = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
        if (!r.speed_e[15] && (r.speed_e[14:0] < cfg_retract_limit)) begin
          flow_smp = (64'(cfg_area) * 64'(r.speed_e[14:0]) + 64'h800) >> 12;
          avg_flow = smooth(avg_flow, flow_smp);
          flow_updates++;
        end
        avg_xy = smooth(avg_xy, xy_root(sum_sq) << 8);
      end else begin
        avg_xy = smooth(avg_xy, 64'd0);
        want.retract_seen = !r.moves_z;
      end
    end else begin
      avg_xy   = smooth(avg_xy, 64'd0);
      avg_flow = smooth(avg_flow, 64'd0);
    end
    want.xy_speed_out = avg_xy;
    want.flow_out     = avg_flow;
    if (want.retract_seen) retract_count++;
    expected_speeds.push_back(want);
  endtask

  task automatic send_request(input smse_pkg::in_item_t r);
    int gap;
    gap = pick_gap(send_idle);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= r;
    do @(posedge clk); while (!in_ready);
    predict_update(r);
    requests_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      smse_pkg::REG_SMOOTHING:     cfg_smoothing     = data;
      smse_pkg::REG_FILAMENT_AREA: cfg_area          = data;
      smse_pkg::REG_RETRACT_LIMIT: cfg_retract_limit = data[14:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic apply_settings(input logic [15:0] sm, input logic [15:0] area,
                                input logic [15:0] lim);
    write_reg(smse_pkg::REG_SMOOTHING, sm);
    write_reg(smse_pkg::REG_FILAMENT_AREA, area);
    write_reg(smse_pkg::REG_RETRACT_LIMIT, lim);
  endtask

  // input goes quiet and every outstanding result is collected
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_speeds.size() != 0) @(posedge clk);
  endtask

  function automatic smse_pkg::in_item_t mk(input bit present, input bit mxy, input bit mz,
                                            input logic [15:0] sx, input logic [15:0] sy,
                                            input logic [15:0] se);
    smse_pkg::in_item_t r;
    r.block_present = present;
    r.moves_xy      = mxy;
    r.moves_z       = mz;
    r.speed_x       = sx;
    r.speed_y       = sy;
    r.speed_e       = se;
    return r;
  endfunction

  function automatic logic [15:0] rand_speed();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return 16'($urandom_range(0, 600)) - 16'd300;
    if (pick < 8) return 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // mostly speeds that update the flow, some negative or past the limit
  function automatic logic [15:0] rand_extrude();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6 && cfg_retract_limit != 0)
      return 16'($urandom_range(0, int'(cfg_retract_limit) - 1));
    if (pick < 8) return 16'($urandom);
    if (pick == 8) return {1'b0, cfg_retract_limit};
    return 16'hFFFF - 16'($urandom_range(0, 3));
  endfunction

  function automatic smse_pkg::in_item_t rand_request();
    smse_pkg::in_item_t r;
    r.block_present = ($urandom_range(0, 9) != 0);
    r.moves_xy      = ($urandom_range(0, 3) != 0);
    r.moves_z       = 1'($urandom_range(0, 1));
    r.speed_x       = rand_speed();
    r.speed_y       = rand_speed();
    r.speed_e       = rand_extrude();
    return r;
  endfunction

  task automatic test_edge_requests();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_request(mk(1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_request(mk(1'b1, 1'b1, 1'b0, 16'h7FFF, 16'h7FFF, 16'd100));
    send_request(mk(1'b1, 1'b1, 1'b1, 16'h8000, 16'h8000, 16'd6399));
    send_request(mk(1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_request(mk(1'b1, 1'b1, 1'b0, 16'd3, 16'hFFFC, 16'd6400));
    send_request(mk(1'b1, 1'b1, 1'b0, 16'h8000, 16'h0000, 16'hFFFF));
    send_request(mk(1'b1, 1'b1, 1'b0, 16'hFFFF, 16'h0001, 16'h8000));
    send_request(mk(1'b1, 1'b1, 1'b1, 16'h7FFF, 16'h8000, 16'h7FFF));
    send_request(mk(1'b1, 1'b0, 1'b1, 16'h7FFF, 16'h7FFF, 16'd200));
    send_request(mk(1'b1, 1'b0, 1'b0, 16'h1234, 16'h4321, 16'd200));
    send_request(mk(1'b1, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(mk(1'b0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(mk(1'b0, 1'b1, 1'b1, 16'h7FFF, 16'h8000, 16'd50));
    send_request(mk(1'b1, 1'b1, 1'b0, 16'd1000, 16'd1000, 16'd3000));
    send_request(mk(1'b1, 1'b1, 1'b0, 16'd1000, 16'd1000, 16'd3000));
    send_request(mk(1'b1, 1'b1, 1'b1, 16'hFC18, 16'd1000, 16'd1));
    drain();
  endtask

  task automatic run_requests(input int n);
    repeat (n) send_request(rand_request());
  endtask

  task automatic test_register_settings();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    // zero smoothing: filter follows the sample at once
    apply_settings(16'h0000, 16'hFFFF, 16'hFFFF);
    run_requests(30);
    drain();
    apply_settings(16'hFFFF, 16'h0000, 16'h0000);
    run_requests(30);
    drain();
    apply_settings(16'h0001, 16'h0001, 16'h0001);
    write_reg(REG_UNUSED, 16'($urandom));
    run_requests(30);
    drain();
    apply_settings(16'h8000, 16'h5555, 16'h2AAA);
    write_reg(REG_UNUSED, 16'hFFFF);
    run_requests(30);
    drain();
    apply_settings(smse_pkg::SMOOTHING_RST, smse_pkg::FILAMENT_AREA_RST,
                   {1'b0, smse_pkg::RETRACT_LIMIT_RST});
    run_requests(30);
    drain();
  endtask

  task automatic test_random_motion();
    for (int chunk = 0; chunk < 4; chunk++) begin
      send_idle = (chunk == 0 || chunk == 2);
      recv_idle = (chunk == 0 || chunk == 3);
      apply_settings(16'($urandom), 16'($urandom), 16'($urandom));
      run_requests(250);
      drain();
    end
  endtask

  task automatic test_output_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    apply_settings(16'($urandom_range(40000, 65535)), 16'($urandom), 16'($urandom));
    long_hold_req = 400;
    run_requests(60);
    drain();
  endtask

  // receiver: random ready gaps, plus a long hold-off when one is requested
  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (long_hold_req > 0) begin
        gap = long_hold_req;
        long_hold_req = 0;
      end else begin
        gap = pick_gap(recv_idle);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, name, want, want, got, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    smse_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_speeds.size() == 0) begin
        $display("%0t: result with no request pending, got xy %0d flow %0d retract %0b",
                 $time, out_item.xy_speed_out, out_item.flow_out, out_item.retract_seen);
        fail_count++;
      end else begin
        want = expected_speeds.pop_front();
        check_field("xy_speed_out", want.xy_speed_out, out_item.xy_speed_out);
        check_field("flow_out", want.flow_out, out_item.flow_out);
        check_field("retract_seen", want.retract_seen, out_item.retract_seen);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no traffic for %0d cycles, %0d results pending",
                 $time, STALL_LIMIT, expected_speeds.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    long_hold_req   = 0;
    fail_count      = 0;
    requests_sent   = 0;
    results_checked = 0;
    reg_writes      = 0;
    retract_count   = 0;
    flow_updates    = 0;
    cfg_smoothing     = smse_pkg::SMOOTHING_RST;
    cfg_area          = smse_pkg::FILAMENT_AREA_RST;
    cfg_retract_limit = smse_pkg::RETRACT_LIMIT_RST;
    avg_xy   = '0;
    avg_flow = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_edge_requests();
    test_register_settings();
    test_random_motion();
    test_output_backpressure();

    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d requests, checked %0d results after %0d register writes.",
             requests_sent, results_checked, reg_writes);
    $display("Saw %0d retract flags and %0d flow filter updates; %0d mismatches.",
             retract_count, flow_updates, fail_count);
    if (fail_count == 0 && expected_speeds.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
design/smse_pkg.sv
design/smoothed_motion_speed_estimator.sv
tb/smoothed_motion_speed_estimator_test.sv
